// ===== design/lfu_replacement_cache_assert.svh =====
// Assertion macros shared by the LFU replacement cache modules.
// Depends on nothing; included by the files that carry assertions.
`ifndef LFU_REPLACEMENT_CACHE_ASSERT_SVH
`define LFU_REPLACEMENT_CACHE_ASSERT_SVH
`ifndef SYNTH
// Same-cycle implication checked on every clock edge outside reset.
`define LFU_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lfu cache check failed");
// Next-cycle implication checked on every clock edge outside reset.
`define LFU_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lfu cache check failed");
`else
`define LFU_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define LFU_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== design/lfu_rc_pkg.sv =====
// Package for the LFU replacement cache: sizes, the sequencer state type and
// the structs that travel between the controller, the cells and the top level.
package lfu_rc_pkg;

   localparam int CAPACITY   = 16;
   localparam int KEY_BITS   = 64;
   localparam int COUNT_BITS = 32;
   localparam int CFG_BITS   = 5;
   localparam int OCC_BITS   = $clog2(CAPACITY + 1);

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
   localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);
   localparam logic [CFG_BITS-1:0]   CAP_RESET = CFG_BITS'(16);

   // Sequencer states, one item at a time.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MATCH,
      ST_COUNT,
      ST_ORDER,
      ST_SHIFT
   } state_type;

   // Phase strobes from the controller.
   typedef struct packed {
      logic load_key;
      logic match_en;
      logic count_en;
      logic order_en;
      logic shift_en;
   } phase_type;

   // Broadcast control for every cell of the chain.
   typedef struct packed {
      logic                  match_en;
      logic                  order_en;
      logic                  shift_en;
      logic                  remove_mode;
      logic                  any_gt;
      logic [KEY_BITS-1:0]   key;
      logic [COUNT_BITS-1:0] thr;
   } cell_ctl_type;

   // What a cell shows its neighbors.
   typedef struct packed {
      logic                  valid;
      logic                  gt;
      logic [KEY_BITS-1:0]   key;
      logic [COUNT_BITS-1:0] count;
   } cell_link_type;

endpackage

// ===== design/lfu_rc_cell.sv =====
// One position of the ordered entry chain: key, use count and two flags.
// Depends on lfu_rc_pkg for the control and neighbor link structs.
module lfu_rc_cell (
   input  logic                           clock,
   input  logic                           reset,
   input  lfu_rc_pkg::cell_ctl_type       ctl,
   input  logic                           valid,
   input  logic                           ge_p,
   input  logic                           after_p,
   input  lfu_rc_pkg::cell_link_type      lo,
   input  lfu_rc_pkg::cell_link_type      hi,
   output lfu_rc_pkg::cell_link_type      link_out,
   output logic                           match
);

   logic [lfu_rc_pkg::KEY_BITS-1:0]   key_ff, key_in;
   logic [lfu_rc_pkg::COUNT_BITS-1:0] count_ff, count_in;
   logic                              match_ff, match_in;
   logic                              gt_ff, gt_in;
   logic                              take_new, take_hi, take_lo;

   // Shift decisions from this cell's flags and its two neighbors.
   always_comb begin
      take_new = 1'b0;
      take_hi  = 1'b0;
      take_lo  = 1'b0;
      if (ctl.remove_mode) begin
         // The entry leaves its place; later entries slide down until the
         // first one whose count is above the new count.
         take_new = (hi.gt && !gt_ff) || (!ctl.any_gt && valid && !hi.valid);
         take_hi  = ge_p && hi.valid && !hi.gt;
      end else begin
         // A new entry goes in before the first count above one.
         take_new = (gt_ff && !lo.gt) || (!ctl.any_gt && !valid && lo.valid);
         take_lo  = lo.gt;
      end
   end

   // Next values of the entry and flags for each phase.
   always_comb begin
      key_in   = key_ff;
      count_in = count_ff;
      match_in = match_ff;
      gt_in    = gt_ff;
      if (ctl.match_en) begin
         match_in = valid && (key_ff == ctl.key);
      end
      if (ctl.order_en) begin
         gt_in = valid && (count_ff > ctl.thr) && (!ctl.remove_mode || after_p);
      end
      if (ctl.shift_en) begin
         if (take_new) begin
            key_in   = ctl.key;
            count_in = ctl.thr;
         end else if (take_hi) begin
            key_in   = hi.key;
            count_in = hi.count;
         end else if (take_lo) begin
            key_in   = lo.key;
            count_in = lo.count;
         end
      end
   end

   // Flags are control state; the entry itself needs no reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         match_ff <= 1'b0;
         gt_ff    <= 1'b0;
      end else begin
         match_ff <= match_in;
         gt_ff    <= gt_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff   <= key_in;
      count_ff <= count_in;
   end

   assign link_out.valid = valid;
   assign link_out.gt    = gt_ff;
   assign link_out.key   = key_ff;
   assign link_out.count = count_ff;
   assign match          = match_ff;

endmodule

// ===== design/lfu_rc_ctrl.sv =====
// Sequencer for the LFU replacement cache: walks each item through the
// match, count, order and shift phases. Depends on lfu_rc_pkg.
module lfu_rc_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   out_free,
   output logic                   req_stall,
   output lfu_rc_pkg::phase_type  phase
);

   lfu_rc_pkg::state_type state_ff, state_in;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         lfu_rc_pkg::ST_IDLE:  if (req_valid) state_in = lfu_rc_pkg::ST_MATCH;
         lfu_rc_pkg::ST_MATCH: state_in = lfu_rc_pkg::ST_COUNT;
         lfu_rc_pkg::ST_COUNT: state_in = lfu_rc_pkg::ST_ORDER;
         lfu_rc_pkg::ST_ORDER: state_in = lfu_rc_pkg::ST_SHIFT;
         lfu_rc_pkg::ST_SHIFT: if (out_free) state_in = lfu_rc_pkg::ST_IDLE;
         default:              state_in = lfu_rc_pkg::ST_IDLE;
      endcase
   end

   // Phase strobes and input stall.
   always_comb begin
      phase     = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         lfu_rc_pkg::ST_IDLE: begin
            req_stall      = 1'b0;
            phase.load_key = req_valid;
         end
         lfu_rc_pkg::ST_MATCH: phase.match_en = 1'b1;
         lfu_rc_pkg::ST_COUNT: phase.count_en = 1'b1;
         lfu_rc_pkg::ST_ORDER: phase.order_en = 1'b1;
         lfu_rc_pkg::ST_SHIFT: phase.shift_en = out_free;
         default: begin
            phase     = '0;
            req_stall = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lfu_rc_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== design/lfu_replacement_cache.sv =====
// LFU replacement cache, top level.
//
// Request channel: req_valid / req_stall with req_query_key. An item is
// taken when req_valid is high and req_stall is low.
// Response channel: rsp_valid / rsp_stall with rsp_hit, rsp_evicted and
// rsp_evicted_key (zero when nothing was evicted). One response per item.
// Configuration: csr_wr_en writes csr_capacity_in_use; zero acts as one,
// values above sixteen act as sixteen. Write it only while the block is idle.
//
// Entries sit in a chain of sixteen cells ordered from least to most used.
// Each item passes through capture, parallel key compare in every cell,
// count select and increment, count compare in every cell, and one shift of
// the chain. The next item is taken in the cycle after the shift, so the
// block takes no new item until the last one has been shifted; rsp_valid
// rises at the edge that ends the shift phase, together with the response fields.
// The response sits in an output register: a stalled receiver holds it, and
// the chain waits in its shift phase until that register is free.
// Synchronous reset empties the cache, sets the capacity to sixteen and
// drops any item in flight; there is no clearing pass.
`include "lfu_replacement_cache_assert.svh"

module lfu_replacement_cache (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [lfu_rc_pkg::KEY_BITS-1:0]     req_query_key,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_hit,
   output logic                                rsp_evicted,
   output logic [lfu_rc_pkg::KEY_BITS-1:0]     rsp_evicted_key,
   input  logic                                csr_wr_en,
   input  logic [lfu_rc_pkg::CFG_BITS-1:0]     csr_capacity_in_use
);

   localparam int N = lfu_rc_pkg::CAPACITY;
   localparam logic [lfu_rc_pkg::CFG_BITS-1:0] CAP_TOP = lfu_rc_pkg::CFG_BITS'(N);

   lfu_rc_pkg::phase_type     phase;
   lfu_rc_pkg::cell_ctl_type  ctl;
   lfu_rc_pkg::cell_link_type links [N];
   lfu_rc_pkg::cell_link_type lo_links [N];
   lfu_rc_pkg::cell_link_type hi_links [N];

   logic [N-1:0] match_vec, valid_vec, ge_vec, gt_vec;

   logic [lfu_rc_pkg::KEY_BITS-1:0]   key_ff, victim_ff;
   logic [lfu_rc_pkg::CFG_BITS-1:0]   capacity_ff;
   logic [lfu_rc_pkg::OCC_BITS-1:0]   occ_ff, occ_in, cap_eff;
   logic [lfu_rc_pkg::COUNT_BITS-1:0] thr_ff, thr_in, sel_count;
   logic [N-1:0]                      ge_p_ff, ge_p_in, after_p_ff, after_p_in;
   logic                              hit_ff, hit_in, remove_ff, remove_in;
   logic                              evict_ff, evict_in, full;
   logic                              rsp_valid_ff, rsp_hit_ff, rsp_evicted_ff;
   logic [lfu_rc_pkg::KEY_BITS-1:0]   rsp_key_ff;
   logic                              out_free;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   lfu_rc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .out_free  (out_free),
      .req_stall (req_stall),
      .phase     (phase)
   );

   // Broadcast control for the chain.
   assign ctl.match_en    = phase.match_en;
   assign ctl.order_en    = phase.order_en;
   assign ctl.shift_en    = phase.shift_en;
   assign ctl.remove_mode = remove_ff;
   assign ctl.any_gt      = |gt_vec;
   assign ctl.key         = key_ff;
   assign ctl.thr         = thr_ff;

   // The cell chain with its neighbor links.
   for (genvar g = 0; g < N; g++) begin : g_cell
      assign valid_vec[g] = occ_ff > lfu_rc_pkg::OCC_BITS'(g);
      assign ge_vec[g]    = |match_vec[g:0];
      assign gt_vec[g]    = links[g].gt;

      if (g == 0) begin : g_first
         assign lo_links[g] = '{valid: 1'b1, gt: 1'b0, key: '0, count: '0};
      end else begin : g_mid_lo
         assign lo_links[g] = links[g-1];
      end
      if (g == N - 1) begin : g_last
         assign hi_links[g] = '{valid: 1'b0, gt: 1'b0, key: '0, count: '0};
      end else begin : g_mid_hi
         assign hi_links[g] = links[g+1];
      end

      lfu_rc_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctl      (ctl),
         .valid    (valid_vec[g]),
         .ge_p     (ge_p_ff[g]),
         .after_p  (after_p_ff[g]),
         .lo       (lo_links[g]),
         .hi       (hi_links[g]),
         .link_out (links[g]),
         .match    (match_vec[g])
      );
   end

   // Effective capacity and the full test.
   always_comb begin
      if (capacity_ff == '0) begin
         cap_eff = lfu_rc_pkg::OCC_BITS'(1);
      end else if (capacity_ff > CAP_TOP) begin
         cap_eff = lfu_rc_pkg::OCC_BITS'(N);
      end else begin
         cap_eff = lfu_rc_pkg::OCC_BITS'(capacity_ff);
      end
      full = occ_ff >= cap_eff;
   end

   // Count phase: pick the hit count, form the new count and the move mode.
   always_comb begin
      sel_count = '0;
      for (int i = 0; i < N; i++) begin
         sel_count = sel_count | (match_vec[i] ? links[i].count : '0);
      end
      hit_in    = |match_vec;
      evict_in  = !hit_in && full;
      remove_in = hit_in || full;
      if (hit_in) begin
         thr_in     = (sel_count == lfu_rc_pkg::COUNT_MAX) ? sel_count
                                                          : sel_count + 1'b1;
         ge_p_in    = ge_vec;
         after_p_in = ge_vec & ~match_vec;
      end else begin
         // A miss either inserts or evicts the front entry and reinserts.
         thr_in     = lfu_rc_pkg::COUNT_ONE;
         ge_p_in    = '1;
         after_p_in = ~N'(1);
      end
   end

   // Occupancy grows only when a miss inserts without eviction.
   always_comb begin
      occ_in = occ_ff;
      if (phase.shift_en && !remove_ff) begin
         occ_in = occ_ff + 1'b1;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff  <= lfu_rc_pkg::CAP_RESET;
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         ge_p_ff      <= '0;
         after_p_ff   <= '0;
         remove_ff    <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            capacity_ff <= csr_capacity_in_use;
         end
         occ_ff <= occ_in;
         if (phase.count_en) begin
            ge_p_ff    <= ge_p_in;
            after_p_ff <= after_p_in;
            remove_ff  <= remove_in;
         end
         if (phase.shift_en) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (phase.load_key) begin
         key_ff <= req_query_key;
      end
      if (phase.count_en) begin
         hit_ff    <= hit_in;
         evict_ff  <= evict_in;
         thr_ff    <= thr_in;
         victim_ff <= links[0].key;
      end
      if (phase.shift_en) begin
         rsp_hit_ff     <= hit_ff;
         rsp_evicted_ff <= evict_ff;
         rsp_key_ff     <= evict_ff ? victim_ff : '0;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_hit         = rsp_hit_ff;
   assign rsp_evicted     = rsp_evicted_ff;
   assign rsp_evicted_key = rsp_key_ff;

   // Keys are unique in the chain, so at most one cell matches.
   `LFU_ASSERT_IMPLIES(a_one_match, clock, reset, 1'b1, $onehot0(match_vec))
   // Occupancy never passes the number of cells.
   `LFU_ASSERT_IMPLIES(a_occ_bound, clock, reset, 1'b1, occ_ff <= lfu_rc_pkg::OCC_BITS'(N))
   // An insert without eviction adds exactly one entry.
   `LFU_ASSERT_NEXT(a_occ_grow, clock, reset, phase.shift_en && !remove_ff, occ_ff == $past(occ_ff) + 1'b1)
   // A response never reports both a hit and an eviction.
   `LFU_ASSERT_IMPLIES(a_hit_no_evict, clock, reset, rsp_valid_ff && rsp_hit_ff, !rsp_evicted_ff)

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the LFU replacement cache (lfu_replacement_cache).
// Depends on lfu_rc_pkg; predicts every lookup outcome and compares it with the response.
module testbench;

   // Outcome of one lookup, as the response channel reports it.
   typedef struct packed {
      logic                            hit;
      logic                            evicted;
      logic [lfu_rc_pkg::KEY_BITS-1:0] evicted_key;
   } outcome_type;

   // One row of the directed table: an optional capacity write before the key,
   // and an outcome typed in by hand where it is obvious.
   typedef struct packed {
      logic                            set_cap;
      logic [lfu_rc_pkg::CFG_BITS-1:0] cap;
      logic [lfu_rc_pkg::KEY_BITS-1:0] key;
      logic                            typed;
      outcome_type                     want;
   } probe_row_type;

   localparam int NUM_PROBES  = 22;
   localparam int RANDOM_ITEMS = 1700;
   localparam int IDLE_PCT    = 21;
   localparam longint LIMIT_NS = 64'd5_000_000;
   localparam logic [lfu_rc_pkg::KEY_BITS-1:0] ALL_ONES = '1;
   localparam logic [lfu_rc_pkg::KEY_BITS-1:0] KEY_FIVES = 64'h5555_5555_5555_5555;
   localparam logic [lfu_rc_pkg::KEY_BITS-1:0] KEY_AS    = 64'hAAAA_AAAA_AAAA_AAAA;
   localparam logic [lfu_rc_pkg::KEY_BITS-1:0] KEY_TOP1  = 64'h8000_0000_0000_0001;
   localparam logic [lfu_rc_pkg::KEY_BITS-1:0] KEY_MIXED = 64'h0123_4567_89AB_CDEF;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_valid = 1'b0;
   logic                            req_stall;
   logic [lfu_rc_pkg::KEY_BITS-1:0] req_query_key = '0;
   logic                            rsp_valid;
   logic                            rsp_stall = 1'b0;
   logic                            rsp_hit;
   logic                            rsp_evicted;
   logic [lfu_rc_pkg::KEY_BITS-1:0] rsp_evicted_key;
   logic                            csr_wr_en = 1'b0;
   logic [lfu_rc_pkg::CFG_BITS-1:0] csr_capacity_in_use = '0;

   // Shadow copy of the cache contents, ordered from least to most used.
   logic [lfu_rc_pkg::KEY_BITS-1:0]   held_keys [0:lfu_rc_pkg::CAPACITY-1];
   logic [lfu_rc_pkg::COUNT_BITS-1:0] held_counts [0:lfu_rc_pkg::CAPACITY-1];
   int                                held_n;
   logic [lfu_rc_pkg::CFG_BITS-1:0]   cap_setting;

   outcome_type pending_outcomes [$];
   outcome_type oldest_outcome;
   int          error_count = 0;
   bit          steady = 1'b0;

   probe_row_type probes [0:NUM_PROBES-1] = '{
      '{1'b0, 5'd0,  64'h0,     1'b1, '{1'b0, 1'b0, 64'h0}},
      '{1'b0, 5'd0,  ALL_ONES,  1'b1, '{1'b0, 1'b0, 64'h0}},
      '{1'b0, 5'd0,  64'h0,     1'b1, '{1'b1, 1'b0, 64'h0}},
      '{1'b0, 5'd0,  KEY_TOP1,  1'b1, '{1'b0, 1'b0, 64'h0}},
      // Capacity zero acts as one and sits below the occupancy of three.
      '{1'b1, 5'd0,  KEY_FIVES, 1'b1, '{1'b0, 1'b1, ALL_ONES}},
      '{1'b0, 5'd0,  KEY_AS,    1'b1, '{1'b0, 1'b1, KEY_TOP1}},
      '{1'b0, 5'd0,  64'h0,     1'b1, '{1'b1, 1'b0, 64'h0}},
      '{1'b0, 5'd0,  KEY_FIVES, 1'b1, '{1'b1, 1'b0, 64'h0}},
      '{1'b1, 5'd1,  KEY_MIXED, 1'b1, '{1'b0, 1'b1, KEY_AS}},
      // Capacity above the array size acts as the array size.
      '{1'b1, 5'd31, 64'h2,     1'b0, '0},
      '{1'b0, 5'd0,  64'h2,     1'b0, '0},
      '{1'b0, 5'd0,  64'h4,     1'b0, '0},
      '{1'b0, 5'd0,  KEY_MIXED, 1'b0, '0},
      '{1'b1, 5'd16, 64'h8,     1'b0, '0},
      '{1'b0, 5'd0,  64'h10,    1'b0, '0},
      '{1'b1, 5'd17, 64'h20,    1'b0, '0},
      '{1'b0, 5'd0,  64'h2,     1'b0, '0},
      '{1'b1, 5'd2,  64'h40,    1'b0, '0},
      '{1'b0, 5'd0,  64'h80,    1'b0, '0},
      '{1'b0, 5'd0,  64'h80,    1'b0, '0},
      '{1'b1, 5'd0,  ALL_ONES,  1'b0, '0},
      '{1'b0, 5'd0,  ALL_ONES,  1'b0, '0}
   };

   lfu_replacement_cache DUT (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_query_key       (req_query_key),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_hit             (rsp_hit),
      .rsp_evicted         (rsp_evicted),
      .rsp_evicted_key     (rsp_evicted_key),
      .csr_wr_en           (csr_wr_en),
      .csr_capacity_in_use (csr_capacity_in_use)
   );

   // 8 ns clock.
   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   // Take the entry at pos out of a list of n and put it back with count cnt
   // in front of the first later entry whose count is higher.
   function automatic void move_entry(input int pos, input int n,
                                      input logic [lfu_rc_pkg::KEY_BITS-1:0] k,
                                      input logic [lfu_rc_pkg::COUNT_BITS-1:0] cnt);
      int dst;
      dst = n - 1;
      for (int i = pos; i + 1 < n; i++) begin
         held_keys[i]   = held_keys[i + 1];
         held_counts[i] = held_counts[i + 1];
      end
      for (int i = pos; i + 1 < n; i++) begin
         if (held_counts[i] > cnt) begin
            dst = i;
            break;
         end
      end
      for (int i = n - 1; i > dst; i--) begin
         held_keys[i]   = held_keys[i - 1];
         held_counts[i] = held_counts[i - 1];
      end
      held_keys[dst]   = k;
      held_counts[dst] = cnt;
   endfunction

   // Look a key up in the shadow cache, update it, and return the outcome.
   function automatic outcome_type predict_lookup(input logic [lfu_rc_pkg::KEY_BITS-1:0] k);
      outcome_type                       o;
      int                                n;
      int                                pos;
      int                                dst;
      int                                eff;
      bit                                found;
      logic [lfu_rc_pkg::COUNT_BITS-1:0] c;
      o = '0;
      n = held_n;
      pos = 0;
      found = 1'b0;
      eff = (cap_setting == 0) ? 1 : ((cap_setting > lfu_rc_pkg::CAPACITY) ?
            lfu_rc_pkg::CAPACITY : int'(cap_setting));
      for (int i = 0; i < n; i++) begin
         if (!found && held_keys[i] == k) begin
            found = 1'b1;
            pos = i;
         end
      end
      if (found) begin
         // A hit saturates its count and moves behind equal or lower counts.
         c = held_counts[pos];
         if (c != lfu_rc_pkg::COUNT_MAX) c = c + 1'b1;
         move_entry(pos, n, k, c);
         o.hit = 1'b1;
      end else if (n < eff) begin
         // A miss with room goes in behind every entry of count one.
         dst = n;
         for (int i = 0; i < n; i++) begin
            if (dst == n && held_counts[i] > lfu_rc_pkg::COUNT_ONE) dst = i;
         end
         for (int i = n; i > dst; i--) begin
            held_keys[i]   = held_keys[i - 1];
            held_counts[i] = held_counts[i - 1];
         end
         held_keys[dst]   = k;
         held_counts[dst] = lfu_rc_pkg::COUNT_ONE;
         held_n = n + 1;
      end else begin
         // A miss when full replaces the front entry.
         o.evicted = 1'b1;
         o.evicted_key = held_keys[0];
         move_entry(0, n, k, lfu_rc_pkg::COUNT_ONE);
      end
      return o;
   endfunction

   task automatic report_mismatch(input string what,
                                  input logic [lfu_rc_pkg::KEY_BITS-1:0] got,
                                  input logic [lfu_rc_pkg::KEY_BITS-1:0] want);
      error_count++;
      $display("mismatch on %s at %0t: got %h, expected %h", what, $time, got, want);
   endtask

   // Offer one item, wait until it is taken, and record its expected outcome.
   task automatic send_key(input logic [lfu_rc_pkg::KEY_BITS-1:0] k, input logic use_typed,
                           input outcome_type typed_want);
      outcome_type predicted;
      while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_query_key <= k;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predicted = predict_lookup(k);
      pending_outcomes.push_back(use_typed ? typed_want : predicted);
   endtask

   // Stop sending and wait until every outstanding response has come back.
   task automatic drain;
      req_valid <= 1'b0;
      while (pending_outcomes.size() != 0) @(posedge clock);
   endtask

   task automatic write_capacity(input logic [lfu_rc_pkg::CFG_BITS-1:0] value);
      csr_capacity_in_use <= value;
      csr_wr_en           <= 1'b1;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      cap_setting = value;
   endtask

   // Response side: check every accepted item and stall at random.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_outcomes.size() == 0) begin
               report_mismatch("unexpected response", {63'b0, rsp_valid}, '0);
            end else begin
               oldest_outcome = pending_outcomes.pop_front();
               if (rsp_hit !== oldest_outcome.hit)
                  report_mismatch("hit", {63'b0, rsp_hit}, {63'b0, oldest_outcome.hit});
               if (rsp_evicted !== oldest_outcome.evicted)
                  report_mismatch("evicted", {63'b0, rsp_evicted},
                                  {63'b0, oldest_outcome.evicted});
               if (rsp_evicted_key !== oldest_outcome.evicted_key)
                  report_mismatch("evicted_key", rsp_evicted_key, oldest_outcome.evicted_key);
            end
         end
         rsp_stall <= !steady && ($urandom_range(0, 99) < IDLE_PCT);
      end
   end

   // Stimulus: directed table first, then phases of random lookups.
   initial begin
      logic [lfu_rc_pkg::KEY_BITS-1:0] key_pool [0:31];
      logic [lfu_rc_pkg::CFG_BITS-1:0] phase_cap;
      logic [lfu_rc_pkg::KEY_BITS-1:0] pick;
      int                              sent;
      int                              phase;
      int                              batch;
      int                              eff;
      int                              pool_n;
      int                              a;
      int                              b;
      held_n = 0;
      cap_setting = lfu_rc_pkg::CAP_RESET;
      for (int i = 0; i < lfu_rc_pkg::CAPACITY; i++) begin
         held_keys[i]   = '0;
         held_counts[i] = '0;
      end
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (probes[i]) begin
         if (probes[i].set_cap) begin
            drain();
            write_capacity(probes[i].cap);
         end
         send_key(probes[i].key, probes[i].typed, probes[i].want);
      end

      sent = 0;
      phase = 0;
      while (sent < RANDOM_ITEMS) begin
         // Extremes of the capacity first, then any setting.
         case (phase)
            0: phase_cap = 5'd0;
            1: phase_cap = 5'd16;
            2: phase_cap = 5'd1;
            3: phase_cap = 5'd31;
            4: phase_cap = 5'd2;
            5: phase_cap = 5'd17;
            default: phase_cap = lfu_rc_pkg::CFG_BITS'($urandom_range(0, 31));
         endcase
         drain();
         write_capacity(phase_cap);
         eff = (phase_cap == 0) ? 1 : ((phase_cap > lfu_rc_pkg::CAPACITY) ?
               lfu_rc_pkg::CAPACITY : int'(phase_cap));

         // A working set of the capacity plus up to six keys gives both hits and evictions.
         pool_n = eff + $urandom_range(0, 6);
         for (int i = 0; i < pool_n; i++) begin
            case ($urandom_range(0, 19))
               0:       key_pool[i] = '0;
               1:       key_pool[i] = ALL_ONES;
               default: key_pool[i] = {$urandom, $urandom};
            endcase
         end

         // One long phase runs with neither side idling.
         steady = (phase == 3);
         batch = steady ? 300 : $urandom_range(60, 140);
         for (int j = 0; j < batch && sent < RANDOM_ITEMS; j++) begin
            if ($urandom_range(0, 99) < 85) begin
               // Skew toward low pool indexes so use counts spread apart.
               a = $urandom_range(0, pool_n - 1);
               b = $urandom_range(0, pool_n - 1);
               pick = key_pool[(a < b) ? a : b];
            end else begin
               pick = {$urandom, $urandom};
            end
            send_key(pick, 1'b0, '0);
            sent++;
         end
         steady = 1'b0;
         phase++;
      end

      drain();
      repeat (20) @(posedge clock);
      if (error_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   // Watchdog against a hung handshake.
   initial begin
      #(LIMIT_NS);
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
